// File: hw/rtl/gbs_pkg.sv
// Shared types, widths and constants for the greedy box suppression block.
package gbs_pkg;

   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   localparam int AREA_W  = 30;
   localparam int UNION_W = 31;
   localparam int THR_W   = 16;
   localparam int PROD_W  = 47;
   localparam int FRAC_W  = 16;
   localparam int SLOT_W  = 6;

   localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [SIZE_W-1:0]         size_type;
   typedef logic [AREA_W-1:0]         area_type;
   typedef logic [THR_W-1:0]          thr_type;
   typedef logic [SLOT_W-1:0]         slot_type;

   // One stored box of the kept list, as it sits in the kept-box RAM.
   typedef struct packed {
      coord_type left;
      coord_type top;
      size_type  width;
      size_type  height;
      area_type  area;
   } kept_entry_type;

   // Sequencer to compare unit: one RAM read was issued this cycle.
   typedef struct packed {
      logic valid;
      logic last;
   } scan_issue_type;

   // Compare unit to sequencer: verdict for one stored box.
   typedef struct packed {
      logic valid;
      logic last;
      logic hit;
   } cmp_result_type;

endpackage

// File: hw/rtl/gbs_if.sv
// Valid/ready channel interfaces for box requests and suppression responses.
interface gbs_req_if;
   logic                valid;
   logic                ready;
   logic                start_of_set;
   gbs_pkg::coord_type  box_left;
   gbs_pkg::coord_type  box_top;
   gbs_pkg::size_type   box_width;
   gbs_pkg::size_type   box_height;

   modport source (output valid, output start_of_set, output box_left, output box_top,
                   output box_width, output box_height, input ready);
   modport sink   (input valid, input start_of_set, input box_left, input box_top,
                   input box_width, input box_height, output ready);
endinterface

interface gbs_rsp_if;
   logic                valid;
   logic                ready;
   logic                keep;
   gbs_pkg::slot_type   kept_slot;
   logic                list_full;

   modport source (output valid, output keep, output kept_slot, output list_full,
                   input ready);
   modport sink   (input valid, input keep, input kept_slot, input list_full,
                   output ready);
endinterface

// File: hw/rtl/gbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module gbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gbs_iou_unit.sv
// Pipelined overlap and IoU threshold compare, shared by every stored box of a scan.
module gbs_iou_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  gbs_pkg::scan_issue_type issue,
   input  gbs_pkg::kept_entry_type kept,
   input  gbs_pkg::coord_type      box_left,
   input  gbs_pkg::coord_type      box_top,
   input  gbs_pkg::size_type       box_width,
   input  gbs_pkg::size_type       box_height,
   input  gbs_pkg::area_type       box_area,
   input  gbs_pkg::thr_type        threshold,
   output gbs_pkg::cmp_result_type result
);

   // Overlap of two intervals on one axis, zero when they do not meet.
   function automatic gbs_pkg::size_type axis_overlap(
      input gbs_pkg::coord_type a0, input gbs_pkg::size_type aw,
      input gbs_pkg::coord_type b0, input gbs_pkg::size_type bw);
      logic signed [gbs_pkg::COORD_W:0]   a1;
      logic signed [gbs_pkg::COORD_W:0]   b1;
      logic signed [gbs_pkg::COORD_W:0]   lo;
      logic signed [gbs_pkg::COORD_W:0]   hi;
      logic signed [gbs_pkg::COORD_W+1:0] diff;
      a1   = (gbs_pkg::COORD_W+1)'(a0) + $signed({2'b00, aw});
      b1   = (gbs_pkg::COORD_W+1)'(b0) + $signed({2'b00, bw});
      lo   = (a0 > b0) ? (gbs_pkg::COORD_W+1)'(a0) : (gbs_pkg::COORD_W+1)'(b0);
      hi   = (a1 < b1) ? a1 : b1;
      diff = (gbs_pkg::COORD_W+2)'(hi) - (gbs_pkg::COORD_W+2)'(lo);
      return (diff > 0) ? diff[gbs_pkg::SIZE_W-1:0] : '0;
   endfunction

   // Stage valid/last flags; stage 0 lines up with the RAM read data.
   gbs_pkg::scan_issue_type s0_ff, s1_ff, s2_ff, s3_ff, s4_ff;
   logic                    hit_ff, hit_in;

   gbs_pkg::size_type          ov_x_ff, ov_y_ff;
   gbs_pkg::area_type          karea1_ff, karea2_ff;
   gbs_pkg::area_type          inter2_ff, inter3_ff, inter4_ff;
   logic [gbs_pkg::UNION_W-1:0] union3_ff;
   logic [gbs_pkg::PROD_W-1:0]  prod4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         s4_ff <= '0;
      end else begin
         s0_ff <= issue;
         s1_ff <= s0_ff;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      ov_x_ff   <= axis_overlap(box_left, box_width, kept.left, kept.width);
      ov_y_ff   <= axis_overlap(box_top, box_height, kept.top, kept.height);
      karea1_ff <= kept.area;
      inter2_ff <= gbs_pkg::AREA_W'(ov_x_ff) * gbs_pkg::AREA_W'(ov_y_ff);
      karea2_ff <= karea1_ff;
      union3_ff <= gbs_pkg::UNION_W'(box_area) + gbs_pkg::UNION_W'(karea2_ff)
                   - gbs_pkg::UNION_W'(inter2_ff);
      inter3_ff <= inter2_ff;
      prod4_ff  <= gbs_pkg::PROD_W'(threshold) * gbs_pkg::PROD_W'(union3_ff);
      inter4_ff <= inter3_ff;
      hit_ff    <= hit_in;
   end

   // Suppress when inter / union > threshold, i.e. inter * 2^16 > threshold * union.
   assign hit_in = gbs_pkg::PROD_W'({inter4_ff, {gbs_pkg::FRAC_W{1'b0}}}) > prod4_ff;

   logic result_valid_ff, result_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
         result_last_ff  <= 1'b0;
      end else begin
         result_valid_ff <= s4_ff.valid;
         result_last_ff  <= s4_ff.last;
      end
   end

   assign result.valid = result_valid_ff;
   assign result.last  = result_last_ff;
   assign result.hit   = hit_ff;

endmodule

// File: hw/rtl/greedy_box_suppression.sv
// Top level of the greedy box suppression block: sequencer, kept-box RAM and compare unit.
//
// Boxes arrive on req_chan already sorted by descending score, one transfer per box.
// A box with start_of_set high first empties the kept list. Each box produces exactly
// one transfer on rsp_chan: keep tells whether it survived, kept_slot is the slot it was
// stored in, and list_full flags a survivor that found the list full and was not stored.
// The IoU threshold is written through csr_wr_en / csr_wr_data; the user must do this only
// while the block is idle, and the block itself does not enforce it.
//
// After a box is accepted, the sequencer reads each box kept so far in the set (at most
// MAX_KEPT) from the kept-box RAM one per cycle and streams them through the pipelined
// compare unit, which performs one overlap/IoU test per cycle. The sequencer then drains
// the compare pipeline; in its done state it loads the verdict into the output register
// and returns to idle. A box with start_of_set high or arriving on an empty list skips
// the scan and goes straight to the done state. The single RAM read port and the compare
// unit set the pace. A finished result sits in an output register until rsp_chan takes
// it, and the next box may already be accepted and scanned meanwhile; if the receiver
// still stalls when that box is done, the block waits and accepts nothing more. Reset
// empties the kept list, drops any pending result and restores the default threshold.
module greedy_box_suppression #(
   parameter int MAX_KEPT = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   gbs_req_if.sink              req_chan,
   gbs_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  gbs_pkg::thr_type     csr_wr_data
);

   localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W  = $clog2(MAX_KEPT + 1);
   localparam int ENTRY_W = $bits(gbs_pkg::kept_entry_type);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                supp_ff, supp_in;
   gbs_pkg::thr_type    thr_ff, thr_in;

   // The box under test; held for the whole scan.
   gbs_pkg::coord_type  box_left_ff, box_top_ff;
   gbs_pkg::size_type   box_width_ff, box_height_ff;
   gbs_pkg::area_type   box_area_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_keep_ff, rsp_keep_in;
   gbs_pkg::slot_type   rsp_slot_ff, rsp_slot_in;
   logic                rsp_full_ff, rsp_full_in;

   logic                    req_xfer;
   logic                    rsp_free;
   logic                    list_is_full;
   logic                    ram_wr_en;
   gbs_pkg::kept_entry_type ram_wr_entry;
   logic [ENTRY_W-1:0]      ram_rd_data;
   gbs_pkg::kept_entry_type ram_rd_entry;
   gbs_pkg::scan_issue_type issue;
   gbs_pkg::cmp_result_type cmp_result;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   // The output register can take a new result when empty or being drained this cycle.
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign list_is_full   = (count_ff == CNT_W'(MAX_KEPT));

   assign issue.valid = (state_ff == ST_SCAN);
   assign issue.last  = (state_ff == ST_SCAN) && (idx_ff == count_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      supp_in      = supp_ff;
      thr_in       = csr_wr_en ? csr_wr_data : thr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_keep_in  = rsp_keep_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_full_in  = rsp_full_ff;
      ram_wr_en    = 1'b0;

      // Any verdict coming out of the compare unit folds into the suppress flag.
      if (cmp_result.valid && cmp_result.hit) begin
         supp_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               idx_in  = '0;
               supp_in = 1'b0;
               if (req_chan.start_of_set) begin
                  count_in = '0;
               end
               // An empty list has nothing to compare against.
               if (req_chan.start_of_set || count_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + CNT_W'(1);
            if (issue.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cmp_result.valid && cmp_result.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_keep_in  = !supp_ff;
               rsp_full_in  = !supp_ff && list_is_full;
               rsp_slot_in  = '0;
               if (!supp_ff && !list_is_full) begin
                  ram_wr_en   = 1'b1;
                  rsp_slot_in = gbs_pkg::SLOT_W'(count_ff);
                  count_in    = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         supp_ff      <= 1'b0;
         thr_ff       <= gbs_pkg::THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         supp_ff      <= supp_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_keep_ff <= rsp_keep_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_full_ff <= rsp_full_in;
      if (req_xfer) begin
         box_left_ff   <= req_chan.box_left;
         box_top_ff    <= req_chan.box_top;
         box_width_ff  <= req_chan.box_width;
         box_height_ff <= req_chan.box_height;
         box_area_ff   <= gbs_pkg::AREA_W'(req_chan.box_width)
                          * gbs_pkg::AREA_W'(req_chan.box_height);
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.keep      = rsp_keep_ff;
   assign rsp_chan.kept_slot = rsp_slot_ff;
   assign rsp_chan.list_full = rsp_full_ff;

   assign ram_wr_entry.left   = box_left_ff;
   assign ram_wr_entry.top    = box_top_ff;
   assign ram_wr_entry.width  = box_width_ff;
   assign ram_wr_entry.height = box_height_ff;
   assign ram_wr_entry.area   = box_area_ff;
   assign ram_rd_entry        = ram_rd_data;

   gbs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_KEPT)
   ) u_kept_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (ram_wr_entry),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   gbs_iou_unit u_iou (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .kept       (ram_rd_entry),
      .box_left   (box_left_ff),
      .box_top    (box_top_ff),
      .box_width  (box_width_ff),
      .box_height (box_height_ff),
      .box_area   (box_area_ff),
      .threshold  (thr_ff),
      .result     (cmp_result)
   );

endmodule

// File: hw/rtl/gbs_checker.sv
// Port-level checks for the greedy box suppression block, bound to its top level.
module gbs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_keep,
   input gbs_pkg::slot_type rsp_kept_slot,
   input logic              rsp_list_full
);

   // A pending result stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A stalled result keeps its fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_keep) && $stable(rsp_kept_slot) && $stable(rsp_list_full))
      else $error("result fields changed while stalled");

   // Each box is handled on its own: ready drops right after a box transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second box accepted while one is in work");

   // A suppressed box reports no slot and no full list.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_keep |-> rsp_kept_slot == '0 && !rsp_list_full)
      else $error("suppressed box carries slot or full flag");

   // A full list is only reported for a survivor, and then without a slot.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_full |-> rsp_keep && rsp_kept_slot == '0)
      else $error("full flag on a dropped box or with a slot");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_keep      (rsp_chan.keep),
   .rsp_kept_slot (rsp_chan.kept_slot),
   .rsp_list_full (rsp_chan.list_full)
);
